>>> sv/lfr_pkg.sv
// Shared types and constants for the LRU frame replacement block.
package lfr_pkg;

  localparam int unsigned FRAME_W    = 4;
  localparam int unsigned FRAMES_DEF = 16;
  localparam int unsigned TDATA_W    = 8;

  localparam logic MODE_REF     = 1'b0;
  localparam logic MODE_REPLACE = 1'b1;

  // Broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic               is_ref;  // compare stored frames against key
    logic               move;    // shift from first hit down, key goes to tail
    logic               append;  // key goes to the first free cell
    logic [FRAME_W-1:0] key;
  } cell_ctl_t;

endpackage

>>> sv/lfr_cell.sv
// One cell of the recency row: holds a frame number and a valid flag.
module lfr_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lfr_pkg::cell_ctl_t        ctl_i,
  input  logic                      hit_i,
  output logic                      hit_o,
  input  logic                      prev_valid_i,
  input  logic                      next_valid_i,
  input  logic [lfr_pkg::FRAME_W-1:0] next_value_i,
  output logic                      valid_o,
  output logic [lfr_pkg::FRAME_W-1:0] value_o
);
  import lfr_pkg::*;

  logic               valid_q, valid_d;
  logic [FRAME_W-1:0] value_q, value_d;
  logic               match;
  logic               is_tail;

  assign match   = ctl_i.is_ref && valid_q && (value_q == ctl_i.key);
  assign hit_o   = hit_i || match;
  assign is_tail = valid_q && !next_valid_i;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctl_i.move && hit_o && valid_q) begin
      value_d = is_tail ? ctl_i.key : next_value_i;
    end else if (ctl_i.append && !valid_q && prev_valid_i) begin
      value_d = ctl_i.key;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

>>> sv/lru_frame_replacement.sv
// Top level of the LRU frame replacement block: cell row, control and result register.
// Keeps tracked frames in a row of cells, least recently used in cell 0. A reference
// (tuser 0) appends an untracked frame while the row has room, or moves a tracked one
// to the tail; a replace (tuser 1) returns the head frame as victim and rotates it to
// the tail, or flags empty_error when nothing is tracked. One transaction is taken per
// cycle while the output register is empty or read; its result is registered there in
// the next cycle. A hit chain through all FRAMES cells locates the shift point.
module lru_frame_replacement #(
  parameter int unsigned FRAMES = lfr_pkg::FRAMES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [lfr_pkg::TDATA_W-1:0] s_axis_tdata_i,   // [3:0] frame
  input  logic                        s_axis_tuser_i,   // [0] mode
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [lfr_pkg::TDATA_W-1:0] m_axis_tdata_o,   // [3:0] victim_frame
  output logic                        m_axis_tuser_o    // [0] empty_error
);
  import lfr_pkg::*;

  logic [FRAMES:0]               hit;
  logic [FRAMES-1:0]             cell_valid;
  logic [FRAMES-1:0][FRAME_W-1:0] cell_value;
  logic [FRAMES-1:0]             prev_valid;
  logic [FRAMES-1:0]             next_valid;
  logic [FRAMES-1:0][FRAME_W-1:0] next_value;

  cell_ctl_t          ctl;
  logic               accept;
  logic [FRAME_W-1:0] frame;
  logic               mode;
  logic               in_range;
  logic               found;
  logic               empty;
  logic               full;

  logic               out_valid_q;
  logic [FRAME_W-1:0] out_frame_q, out_frame_d;
  logic               out_err_q, out_err_d;

  assign frame    = s_axis_tdata_i[FRAME_W-1:0];
  assign mode     = s_axis_tuser_i;
  assign in_range = 32'(frame) < FRAMES;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  assign empty = !cell_valid[0];
  assign full  = cell_valid[FRAMES-1];
  assign found = hit[FRAMES];

  assign hit[0]     = (mode == MODE_REPLACE);
  assign prev_valid = {cell_valid[FRAMES-2:0], 1'b1};
  assign next_valid = {1'b0, cell_valid[FRAMES-1:1]};
  assign next_value = {{FRAME_W{1'b0}}, cell_value[FRAMES-1:1]};

  always_comb begin
    ctl.is_ref = (mode == MODE_REF) && in_range;
    ctl.key    = (mode == MODE_REPLACE) ? cell_value[0] : frame;
    ctl.move   = accept && ((mode == MODE_REPLACE) ? !empty : (ctl.is_ref && found));
    ctl.append = accept && ctl.is_ref && !found && !full;
  end

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lfr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .hit_i        (hit[i]),
      .hit_o        (hit[i+1]),
      .prev_valid_i (prev_valid[i]),
      .next_valid_i (next_valid[i]),
      .next_value_i (next_value[i]),
      .valid_o      (cell_valid[i]),
      .value_o      (cell_value[i])
    );
  end

  always_comb begin
    out_frame_d = frame;
    out_err_d   = 1'b0;
    if (mode == MODE_REPLACE) begin
      out_frame_d = empty ? '0 : cell_value[0];
      out_err_d   = empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_frame_q <= out_frame_d;
      out_err_q   <= out_err_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(TDATA_W - FRAME_W){1'b0}}, out_frame_q};
  assign m_axis_tuser_o  = out_err_q;

`ifndef SYNTHESIS
  a_empty_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode == MODE_REPLACE) && empty |=> out_valid_q && out_err_q)
    else $error("replace on empty row did not flag empty_error");

  a_no_false_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !((mode == MODE_REPLACE) && empty) |=> out_valid_q && !out_err_q)
    else $error("empty_error raised without an empty replace");

  a_append_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.append |=> cell_valid[0])
    else $error("append left the head cell invalid");

  a_move_keeps_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.move |=> $countones(cell_valid) == $past($countones(cell_valid)))
    else $error("move changed the number of tracked frames");
`endif

endmodule

>>> bench/testbench.sv
// Testbench for lru_frame_replacement: directed and random reference/replace traffic checked against an LRU queue.
module testbench;
  import lfr_pkg::*;

  localparam int unsigned N_FRAMES  = FRAMES_DEF;
  localparam int          WDOG_MAX  = 3000;
  localparam int          HOLD_LEN  = 300;
  localparam int          RAND_ITEMS = 2000;

  typedef struct {
    logic [FRAME_W-1:0] victim;
    logic               empty_err;
  } victim_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;

  logic [FRAME_W-1:0] lru_order[$];
  logic               lru_tracked[N_FRAMES];
  victim_t            pending_victims[$];
  int                 err_count = 0;
  int                 idle_cycles = 0;
  bit                 tx_idle = 1'b0;
  bit                 rx_idle = 1'b0;
  bit                 rx_hold_req = 1'b0;

  lru_frame_replacement #(.FRAMES(N_FRAMES)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic victim_t lru_predict(logic mode, logic [FRAME_W-1:0] frame);
    victim_t            res;
    logic [FRAME_W-1:0] v;
    int                 pos;
    res.victim    = frame;
    res.empty_err = 1'b0;
    if (mode == MODE_REPLACE) begin
      if (lru_order.size() == 0) begin
        res.victim    = '0;
        res.empty_err = 1'b1;
      end else begin
        v = lru_order.pop_front();
        lru_order.push_back(v);
        res.victim = v;
      end
    end else if (!lru_tracked[frame]) begin
      if (lru_order.size() < N_FRAMES) begin
        lru_order.push_back(frame);
        lru_tracked[frame] = 1'b1;
      end
    end else begin
      pos = -1;
      foreach (lru_order[i]) if (pos < 0 && lru_order[i] == frame) pos = i;
      if (pos >= 0) begin
        lru_order.delete(pos);
        lru_order.push_back(frame);
      end
    end
    return res;
  endfunction

  // check output transactions, predict on input transactions
  always @(posedge clk_i) begin
    victim_t got, exp_res;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.victim    = m_tdata[FRAME_W-1:0];
        got.empty_err = m_tuser;
        if (pending_victims.size() == 0) begin
          $error("unexpected result: victim_frame %0d empty_error %0d",
                 got.victim, got.empty_err);
          err_count++;
        end else begin
          exp_res = pending_victims.pop_front();
          if (got.victim !== exp_res.victim) begin
            $error("victim_frame: expected %0d, actual %0d", exp_res.victim, got.victim);
            err_count++;
          end
          if (got.empty_err !== exp_res.empty_err) begin
            $error("empty_error: expected %0d, actual %0d",
                   exp_res.empty_err, got.empty_err);
            err_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_victims.push_back(lru_predict(s_tuser, s_tdata[FRAME_W-1:0]));
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin : rx_proc
    int gap;
    forever begin
      @(posedge clk_i);
      gap = rx_idle ? pick_gap() : 0;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_LEN - 1) @(posedge clk_i);
      end else if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic mode, input logic [FRAME_W-1:0] frame);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W - FRAME_W){1'b0}}, frame};
    s_tuser  <= mode;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_victims.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_item(MODE_REPLACE, 4'd0);   // empty order
    send_item(MODE_REPLACE, 4'd15);  // empty order, frame field ignored
    send_item(MODE_REF, 4'd0);
    send_item(MODE_REF, 4'd0);       // already newest
    send_item(MODE_REF, 4'd15);
    send_item(MODE_REF, 4'd5);
    send_item(MODE_REF, 4'd0);       // move from head
    send_item(MODE_REF, 4'd15);      // move from head
    send_item(MODE_REPLACE, 4'd10);
    for (int f = 1; f < 15; f++) send_item(MODE_REF, f[FRAME_W-1:0]);  // fill the order
    send_item(MODE_REF, 4'd15);      // full order, tracked frame
    send_item(MODE_REPLACE, 4'd0);
    send_item(MODE_REPLACE, 4'd7);
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_item($urandom_range(0, 3) == 0, FRAME_W'($urandom_range(0, N_FRAMES - 1)));
    drain();
  endtask

  task automatic test_random();
    logic               mode;
    logic [FRAME_W-1:0] frame;
    int                 r;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 250 == 0) begin
        tx_idle = bit'((i / 250) % 2);
        rx_idle = bit'((i / 500) % 2);
      end
      mode = ($urandom_range(0, 9) < 3) ? MODE_REPLACE : MODE_REF;
      r = $urandom_range(0, 9);
      if (r < 2 && lru_order.size() != 0)
        frame = lru_order[lru_order.size() - 1];  // newest
      else if (r < 3 && lru_order.size() != 0)
        frame = lru_order[0];                     // oldest
      else
        frame = FRAME_W'($urandom_range(0, N_FRAMES - 1));
      send_item(mode, frame);
    end
    drain();
  endtask

  initial begin
    foreach (lru_tracked[i]) lru_tracked[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    if (err_count == 0 && pending_victims.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
